>>> rtl/core/blsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_pkg
// Shared types, codes and helpers of the byte addressed load/store memory.
// ----------------------------------------------------------------------------
package blsm_pkg;

   localparam int ADDR_W = 32;
   localparam int DATA_W = 32;
   // Low address bits that reach the memory; the two top bits mark unmapped.
   localparam int MAP_W  = 30;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   localparam logic [2:0] WC_BYTE   = 3'b000;
   localparam logic [2:0] WC_HALF   = 3'b001;
   localparam logic [2:0] WC_WORD   = 3'b010;
   localparam logic [2:0] WC_BYTE_U = 3'b100;
   localparam logic [2:0] WC_HALF_U = 3'b101;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ACCESS,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   // Number of bytes an access touches; zero for codes the operation lacks.
   function automatic logic [2:0] access_bytes(input logic is_store,
                                               input logic [2:0] code);
      logic [2:0] n;
      case (code)
         WC_BYTE:   n = 3'd1;
         WC_HALF:   n = 3'd2;
         WC_WORD:   n = 3'd4;
         WC_BYTE_U: n = is_store ? 3'd0 : 3'd1;
         WC_HALF_U: n = is_store ? 3'd0 : 3'd2;
         default:   n = 3'd0;
      endcase
      return n;
   endfunction

   // Sign or zero extend the gathered bytes of a load.
   function automatic logic [DATA_W-1:0] load_extend(input logic [2:0] code,
                                                     input logic [DATA_W-1:0] word);
      logic [DATA_W-1:0] r;
      case (code)
         WC_BYTE:   r = {{24{word[7]}}, word[7:0]};
         WC_HALF:   r = {{16{word[15]}}, word[15:0]};
         WC_WORD:   r = word;
         WC_BYTE_U: r = {24'd0, word[7:0]};
         WC_HALF_U: r = {16'd0, word[15:0]};
         default:   r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/blsm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_req_if
// Request channel: one load or store beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface blsm_req_if
   import blsm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [2:0]        width_code;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] store_data;

   modport source (output valid, output opcode, output width_code,
                   output address, output store_data, input ready);
   modport sink   (input valid, input opcode, input width_code,
                   input address, input store_data, output ready);
endinterface

>>> rtl/core/blsm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_rsp_if
// Response channel: one result beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface blsm_rsp_if
   import blsm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] load_data;

   modport source (output valid, output load_data, input ready);
   modport sink   (input valid, input load_data, output ready);
endinterface

>>> rtl/core/byte_addressed_load_store_memory_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_addressed_load_store_memory_top
// Little-endian byte memory serving RV32I loads (lb lh lw lbu lhu) and
// stores (sb sh sw) with modulo addressing and wrap-around accesses.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake       Beat contents
//   -------  ---  --------------  ---------------------------------------
//   req_bus  in   valid && ready  opcode, width_code, address, store_data
//   rsp_bus  out  valid && ready  load_data (0 for stores and unmapped)
//
// Flow: one request at a time. An accepted request passes through address
//   reduction (a mask for a power of two MEM_BYTES, else reciprocal reduction
//   in the address reducer), one access step per byte (none when unmapped or
//   unsupported), a drain step for a load that touches bytes, and a result step.
//   The single byte-wide RAM port moves one byte per cycle.
// Reset: clears control state only; RAM contents stay undefined until written.
// Stalls: a finished result waits in the response register; a new request
//   is accepted meanwhile and holds in its result step until the slot frees.
// ----------------------------------------------------------------------------
module byte_addressed_load_store_memory_top
   import blsm_pkg::*;
#(
   parameter int MEM_BYTES = 524288
) (
   input  logic         clock,
   input  logic         reset,
   blsm_req_if.sink     req_bus,
   blsm_rsp_if.source   rsp_bus
);

   localparam int IDX_W = $clog2(MEM_BYTES);
   localparam logic [MAP_W-1:0] MEM_LAST = MAP_W'(MEM_BYTES - 1);

   // Control and payload registers.
   state_type         state_ff,     state_in;
   logic              is_store_ff,  is_store_in;
   logic [2:0]        code_ff,      code_in;
   logic [2:0]        nbytes_ff,    nbytes_in;
   logic              none_ff,      none_in;
   logic [1:0]        idx_ff,       idx_in;
   logic [DATA_W-1:0] data_ff,      data_in;
   logic [MAP_W-1:0]  ptr_ff,       ptr_in;
   logic [DATA_W-1:0] word_ff,      word_in;
   logic              rd_pend_ff,   rd_pend_in;
   logic [1:0]        rd_lane_ff,   rd_lane_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   // Byte RAM.
   logic [7:0]        mem_array [MEM_BYTES];
   logic [7:0]        mem_q_ff;
   logic              mem_we;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_idx;
   logic [7:0]        mem_wdata;

   // Address reducer.
   logic              red_start;
   logic              red_done;
   logic [IDX_W-1:0]  red_rem;

   logic              req_fire;
   logic              rsp_load;
   logic [2:0]        req_bytes;
   logic              last_byte;

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign req_fire          = req_bus.valid && req_bus.ready;
   assign req_bytes         = access_bytes(req_bus.opcode == OP_STORE,
                                           req_bus.width_code);
   assign last_byte         = ({1'b0, idx_ff} + 3'd1) == nbytes_ff;
   assign mem_idx           = ptr_ff[IDX_W-1:0];
   assign mem_wdata         = data_ff[{idx_ff, 3'b000} +: 8];
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.load_data = rsp_data_ff;

   blsm_addr_reduce #(
      .MEM_BYTES (MEM_BYTES)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (req_bus.address[MAP_W-1:0]),
      .done      (red_done),
      .remainder (red_rem)
   );

   always_comb begin
      state_in     = state_ff;
      is_store_in  = is_store_ff;
      code_in      = code_ff;
      nbytes_in    = nbytes_ff;
      none_in      = none_ff;
      idx_in       = idx_ff;
      data_in      = data_ff;
      ptr_in       = ptr_ff;
      word_in      = word_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      red_start    = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Latch the beat and start reducing its address.
            if (req_fire) begin
               is_store_in = (req_bus.opcode == OP_STORE);
               code_in     = req_bus.width_code;
               nbytes_in   = req_bytes;
               none_in     = (req_bus.address[ADDR_W-1:MAP_W] != 2'b00)
                             || (req_bytes == 3'd0);
               data_in     = req_bus.store_data;
               word_in     = '0;
               red_start   = 1'b1;
               state_in    = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (red_done) begin
               ptr_in   = MAP_W'(red_rem);
               idx_in   = 2'd0;
               state_in = none_ff ? ST_RESULT : ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            // One byte per cycle; advance the pointer with wrap at the top.
            mem_we = is_store_ff;
            mem_re = !is_store_ff;
            idx_in = idx_ff + 2'd1;
            ptr_in = (ptr_ff == MEM_LAST) ? '0 : ptr_ff + 1'b1;
            if (last_byte) begin
               state_in = is_store_ff ? ST_RESULT : ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Let the last read byte land in the word.
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load    = 1'b1;
               rsp_data_in = (is_store_ff || none_ff) ? '0
                             : load_extend(code_ff, word_ff);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Gather each read byte in the cycle after its read.
      rd_pend_in = mem_re;
      rd_lane_in = idx_ff;
      if (rd_pend_ff) begin
         word_in[{rd_lane_ff, 3'b000} +: 8] = mem_q_ff;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_store_ff <= is_store_in;
      code_ff     <= code_in;
      nbytes_ff   <= nbytes_in;
      none_ff     <= none_in;
      idx_ff      <= idx_in;
      data_ff     <= data_in;
      ptr_ff      <= ptr_in;
      word_ff     <= word_in;
      rd_lane_ff  <= rd_lane_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Byte RAM: one port, registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_idx] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem_array[mem_idx];
      end
   end

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (mem_we || mem_re) |-> (ptr_ff <= MEM_LAST))
      else $error("RAM access beyond memory size");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result step");

   a_no_access_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (is_store_ff || none_ff)) |=> (rsp_data_ff == '0))
      else $error("store or unmapped result not zero");

   a_accept_reduces: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !reset) |=> (state_ff == ST_REDUCE))
      else $error("accepted request did not enter reduction");

endmodule

>>> rtl/core/blsm_addr_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsm_addr_reduce
// Reduces a mapped byte address modulo the memory size: a mask for a power
// of two size, else a reciprocal quotient estimate, a multiply-back and one
// conditional subtract, one step per cycle.
// ----------------------------------------------------------------------------
module blsm_addr_reduce
   import blsm_pkg::*;
#(
   parameter int MEM_BYTES = 524288
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [MAP_W-1:0]              value,
   output logic                          done,
   output logic [$clog2(MEM_BYTES)-1:0]  remainder
);

   localparam int IDX_W   = $clog2(MEM_BYTES);
   localparam bit IS_POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
   localparam int PROD_W  = 2 * MAP_W;
   localparam logic [MAP_W:0]   MEM_SIZE = (MAP_W + 1)'(MEM_BYTES);
   localparam logic [MAP_W-1:0] MEM_MASK = MAP_W'(MEM_BYTES - 1);
   // floor(2^MAP_W / MEM_BYTES); the quotient estimate is short by at most one.
   localparam logic [MAP_W-1:0] RECIP =
      MAP_W'((longint'(1) << MAP_W) / longint'(MEM_BYTES));

   localparam logic [1:0] STEP_EST  = 2'd0;
   localparam logic [1:0] STEP_BACK = 2'd1;
   localparam logic [1:0] STEP_FOLD = 2'd2;

   logic [MAP_W-1:0]  val_ff,   val_in;
   logic [MAP_W-1:0]  quot_ff,  quot_in;
   logic [1:0]        step_ff,  step_in;
   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [PROD_W-1:0] prod;
   logic [MAP_W:0]    back;
   logic              sub_ok;

   assign prod   = PROD_W'(val_ff) * PROD_W'(RECIP);
   assign back   = (MAP_W + 1)'(quot_ff) * MEM_SIZE;
   assign sub_ok = {1'b0, val_ff} >= MEM_SIZE;

   always_comb begin
      val_in  = val_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         val_in  = IS_POW2 ? (value & MEM_MASK) : value;
         step_in = STEP_EST;
         busy_in = !IS_POW2;
         done_in = IS_POW2;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_EST: begin
               quot_in = prod[PROD_W-1:MAP_W];
               step_in = STEP_BACK;
            end
            STEP_BACK: begin
               // Leaves less than twice the memory size.
               val_in  = val_ff - back[MAP_W-1:0];
               step_in = STEP_FOLD;
            end
            default: begin
               if (sub_ok) begin
                  val_in = val_ff - MEM_SIZE[MAP_W-1:0];
               end
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign remainder = val_ff[IDX_W-1:0];

   a_done_in_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, val_ff} < MEM_SIZE))
      else $error("reduced address not below memory size");

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("reduction busy and done together");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (start && !reset) |=> (busy_ff || done_ff))
      else $error("reduction did not start");

endmodule

>>> verif/byte_addressed_load_store_memory_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_addressed_load_store_memory_top_test
// Self-checking bench for the byte addressed load/store memory. A short list
// of hand-picked accesses comes first, then random loads and stores. Every
// accepted request is run through a byte-accurate image of the RAM, and each
// response beat is compared against the oldest predicted load value.
// ----------------------------------------------------------------------------
module byte_addressed_load_store_memory_top_test
   import blsm_pkg::*;
   ();

   localparam int MEM_BYTES      = 524288;
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_PHASES  = 4;
   localparam int BEATS_PER_PHASE = 381;
   // Receiver hold-off: long enough for the block to back up into req_bus.
   localparam int HOLDOFF_AT     = DIRECTED_COUNT + 50;
   localparam int HOLDOFF_CYCLES = 300;
   // Margin after the last beat, longer than the worst access takes.
   localparam int SETTLE_CYCLES  = 20;
   localparam int CYCLE_LIMIT    = 400000;

   // Width codes the block does not support for any operation.
   localparam logic [2:0] WC_RSVD_3 = 3'b011;
   localparam logic [2:0] WC_RSVD_6 = 3'b110;
   localparam logic [2:0] WC_RSVD_7 = 3'b111;

   localparam logic [2:0] LOAD_CODES [5] = '{WC_BYTE, WC_HALF, WC_WORD, WC_BYTE_U, WC_HALF_U};
   localparam logic [2:0] RSVD_CODES [3] = '{WC_RSVD_3, WC_RSVD_6, WC_RSVD_7};

   // One request plus, where it is obvious, the load value it must return.
   typedef struct packed {
      logic              op;
      logic [2:0]        code;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              typed;
      logic [DATA_W-1:0] result;
   } access_row_type;

   // Hand-picked accesses. Byte lanes after the first store: 80 7F 81 80.
   localparam access_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_STORE, WC_WORD,   32'h0000_0000, 32'h8081_7F80, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  WC_WORD,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8081_7F80},
      '{OP_LOAD,  WC_BYTE,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FF80},
      '{OP_LOAD,  WC_BYTE_U, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0080},
      '{OP_LOAD,  WC_HALF,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_7F80},
      '{OP_LOAD,  WC_HALF_U, 32'h0000_0002, 32'h0000_0000, 1'b1, 32'h0000_8081},
      '{OP_LOAD,  WC_HALF,   32'h0000_0002, 32'h0000_0000, 1'b1, 32'hFFFF_8081},
      '{OP_LOAD,  WC_BYTE,   32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_007F},
      '{OP_LOAD,  WC_RSVD_3, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  WC_RSVD_6, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  WC_RSVD_7, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  WC_WORD,   32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_STORE, WC_WORD,   32'h4000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{OP_STORE, WC_BYTE_U, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_STORE, WC_RSVD_7, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  WC_WORD,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8081_7F80},
      // Word store at the last two bytes wraps into bytes 0 and 1.
      '{OP_STORE, WC_WORD,   32'h0007_FFFE, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  WC_WORD,   32'h0007_FFFE, 32'h0000_0000, 1'b1, 32'hDEAD_BEEF},
      '{OP_LOAD,  WC_WORD,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8081_DEAD},
      // Highest mapped address lands on the last byte; the half wraps.
      '{OP_STORE, WC_HALF,   32'h3FFF_FFFF, 32'h1234_A5C3, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  WC_HALF_U, 32'h0007_FFFF, 32'h0000_0000, 1'b1, 32'h0000_A5C3},
      '{OP_LOAD,  WC_HALF,   32'h3FFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_A5C3},
      '{OP_STORE, WC_BYTE,   32'h0008_0003, 32'hFFFF_FF00, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  WC_WORD,   32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  WC_BYTE_U, 32'hC007_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000}
   };

   logic clock = 1'b0;
   logic reset;

   blsm_req_if req_bus ();
   blsm_rsp_if rsp_bus ();

   byte_addressed_load_store_memory_top #(
      .MEM_BYTES(MEM_BYTES)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted RAM contents; only bytes written since reset exist here.
   logic [7:0]        ram_image [int unsigned];
   // Bases of mapped stores that wrote at least their first byte.
   int unsigned       store_bases [$];
   logic [DATA_W-1:0] load_data_expected [$];
   logic [DATA_W-1:0] load_data_wanted;
   int                mismatch_count = 0;
   int                beats_sent = 0;
   int                req_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                holdoff_left = 0;
   bit                holdoff_done = 1'b0;
   int                cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bytes an access touches; zero where the operation has no such code.
   function automatic int unsigned access_span(input logic op, input logic [2:0] code);
      if (code == WC_WORD) return 4;
      if (code == WC_HALF || (op == OP_LOAD && code == WC_HALF_U)) return 2;
      if (code == WC_BYTE || (op == OP_LOAD && code == WC_BYTE_U)) return 1;
      return 0;
   endfunction

   // Apply one request to the RAM image and return the load_data it yields.
   function automatic logic [DATA_W-1:0] access_ram_image(input access_row_type row);
      int unsigned       base;
      int unsigned       span;
      logic [DATA_W-1:0] word;
      base = row.addr % MEM_BYTES;
      span = access_span(row.op, row.code);
      word = '0;
      // Unmapped region: loads read zero, stores are dropped.
      if ((row.addr >> MAP_W) != 0) return '0;
      for (int k = 0; k < span; k++) begin
         if (row.op == OP_STORE)
            ram_image[(base + k) % MEM_BYTES] = row.data[8*k +: 8];
         else
            word[8*k +: 8] = ram_image[(base + k) % MEM_BYTES];
      end
      if (row.op == OP_STORE) return '0;
      case (row.code)
         WC_BYTE: return DATA_W'($signed(word[7:0]));
         WC_HALF: return DATA_W'($signed(word[15:0]));
         default: return word;
      endcase
   endfunction

   // Offer one beat, hold it until accepted, then record what it must return.
   task automatic send_beat(input access_row_type row);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= row.op;
      req_bus.width_code <= row.code;
      req_bus.address    <= row.addr;
      req_bus.store_data <= row.data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // Accepted at this edge: update the image in request order.
      if (row.typed) begin
         void'(access_ram_image(row));
         load_data_expected.push_back(row.result);
      end else begin
         load_data_expected.push_back(access_ram_image(row));
      end
      if (row.op == OP_STORE && (row.addr >> MAP_W) == 0 && access_span(row.op, row.code) != 0)
         store_bases.push_back(row.addr % MEM_BYTES);
      beats_sent <= beats_sent + 1;
   endtask

   // Random request: stores cluster near both ends of the RAM so accesses
   // wrap often; most loads revisit written bytes, the rest are the cases
   // that read nothing (unmapped region, unsupported code).
   task automatic send_random_beat();
      access_row_type row;
      int unsigned anchor;
      int unsigned base;
      int unsigned span;
      bit          covered;
      row      = '0;
      row.data = $urandom();
      row.addr = $urandom();
      row.addr[ADDR_W-1:MAP_W] = '0;
      if ($urandom_range(0, 99) < 45 || store_bases.size() == 0) begin
         row.op = OP_STORE;
         case ($urandom_range(0, 9))
            0, 1, 2: row.code = WC_BYTE;
            3, 4, 5: row.code = WC_HALF;
            6, 7, 8: row.code = WC_WORD;
            default: row.code = 3'($urandom_range(WC_RSVD_3, WC_RSVD_7));
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: base = $urandom_range(0, 255);
            4, 5, 6:    base = MEM_BYTES - 256 + $urandom_range(0, 255);
            default:    base = $urandom_range(0, MEM_BYTES - 1);
         endcase
         row.addr = row.addr - row.addr % MEM_BYTES + base;
         if ($urandom_range(0, 9) == 0)
            row.addr[ADDR_W-1:MAP_W] = 2'($urandom_range(1, 3));
      end else begin
         row.op = OP_LOAD;
         case ($urandom_range(0, 19))
            0: begin
               row.code = 3'($urandom());
               row.addr[ADDR_W-1:MAP_W] = 2'($urandom_range(1, 3));
            end
            1: row.code = RSVD_CODES[$urandom_range(0, 2)];
            default: begin
               // Land on or just past a written byte; fall back to a single
               // byte at the store base when any touched byte is unwritten.
               anchor   = store_bases[$urandom_range(0, store_bases.size() - 1)];
               base     = (anchor + $urandom_range(0, 3)) % MEM_BYTES;
               row.code = LOAD_CODES[$urandom_range(0, 4)];
               span     = access_span(OP_LOAD, row.code);
               covered  = 1'b1;
               for (int k = 0; k < span; k++)
                  if (!ram_image.exists((base + k) % MEM_BYTES)) covered = 1'b0;
               if (!covered) begin
                  base     = anchor;
                  row.code = $urandom_range(0, 1) ? WC_BYTE : WC_BYTE_U;
               end
               row.addr = row.addr - row.addr % MEM_BYTES + base;
            end
         endcase
      end
      send_beat(row);
   endtask

   // Drop valid and hold until every outstanding response has come back.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (load_data_expected.size() != 0) @(posedge clock);
   endtask

   // Response side: check each accepted beat, then pick ready for the next
   // cycle. One long hold-off lets the block fill up and stall req_bus.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (load_data_expected.size() == 0) begin
               $display("%0t: unexpected load_data beat, expected none, got %h",
                        $time, rsp_bus.load_data);
               mismatch_count++;
            end else begin
               load_data_wanted = load_data_expected.pop_front();
               if (rsp_bus.load_data !== load_data_wanted) begin
                  $display("%0t: load_data mismatch, expected %h, got %h",
                           $time, load_data_wanted, rsp_bus.load_data);
                  mismatch_count++;
               end
            end
         end
         if (holdoff_left != 0) begin
            holdoff_left  <= holdoff_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!holdoff_done && beats_sent >= HOLDOFF_AT) begin
            holdoff_done  <= 1'b1;
            holdoff_left  <= HOLDOFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      // Known values on the request inputs before the first edge.
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_LOAD;
      req_bus.width_code = WC_BYTE;
      req_bus.address    = '0;
      req_bus.store_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed accesses, no idling on either side.
      foreach (DIRECTED_ROWS[i]) send_beat(DIRECTED_ROWS[i]);
      wait_for_results();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 50; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 50; end
            default: begin req_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         repeat (BEATS_PER_PHASE) send_random_beat();
         wait_for_results();
      end

      // Let any stray beat surface before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> byte_addressed_load_store_memory_top.f
rtl/core/blsm_pkg.sv
rtl/core/blsm_req_if.sv
rtl/core/blsm_rsp_if.sv
rtl/core/blsm_addr_reduce.sv
rtl/core/byte_addressed_load_store_memory_top.sv
verif/byte_addressed_load_store_memory_top_test.sv
